// ===== hw/rtl/csp_pkg.sv =====
package csp_pkg;

    localparam int CMD_W  = 3;
    localparam int BID_W  = 10;
    localparam int SIDX_W = 6;
    localparam int SST_W  = 2;
    localparam int POS_W  = 7;

    localparam logic [CMD_W-1:0] CMD_FIND     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_SLOT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_MAP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_MAP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_MAP = 3'd4;

    localparam logic [SST_W-1:0] ST_EMPTY  = 2'd0;
    localparam logic [SST_W-1:0] ST_UNUSED = 2'd1;

    // -1 in the map: no slot
    localparam logic [POS_W-1:0] NONE_POS = 7'h7f;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_MAPRD,
        S_MAPCHK,
        S_RDMAP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_en;
        logic mod_step;
        logic probe_step;
        logic probe_hit;
        logic probe_full;
        logic map_rd_own;
        logic map_rd_bid;
        logic map_chk;
        logic exec;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic chk_v;
        logic hit;
        logic unused;
        logic own_ok;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/cache_slot_probe_allocator.sv =====
// Find: 1 to SLOTS slots probed, one slot read a cycle; an unused slot
// may be evicted. S_EXEC does set slot, set map and clear map, S_RDMAP
// read map; unknown commands only return a result. One item in work at a
// time; the next is taken while a result waits. Reset is synchronous;
// afterwards a clearing pass over max(SLOTS, BLOCK_IDS) entries empties
// the slots and sets the map to -1, input stalled meanwhile.
module cache_slot_probe_allocator
    import csp_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int BLOCK_IDS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [BID_W-1:0]        i_block_id,
    input  logic [SIDX_W-1:0]       i_slot_index,
    input  logic [SST_W-1:0]        i_slot_status,
    input  logic signed [POS_W-1:0] i_position,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SIDX_W-1:0]       o_slot_found,
    output logic signed [POS_W-1:0] o_position_out,
    output logic                    o_write_back,
    output logic [BID_W-1:0]        o_write_back_id,
    output logic                    o_full_error
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    csp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_stall (o_stall)
    );

    csp_dp #(
        .SLOTS     (SLOTS),
        .BLOCK_IDS (BLOCK_IDS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (dp_cmd),
        .o_sts           (dp_sts),
        .i_cmd           (i_cmd),
        .i_block_id      (i_block_id),
        .i_slot_index    (i_slot_index),
        .i_slot_status   (i_slot_status),
        .i_position      (i_position),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_slot_found    (o_slot_found),
        .o_position_out  (o_position_out),
        .o_write_back    (o_write_back),
        .o_write_back_id (o_write_back_id),
        .o_full_error    (o_full_error)
    );

endmodule

// ===== hw/rtl/csp_ctrl.sv =====
module csp_ctrl
    import csp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd,
    output logic             o_stall
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // r_done marks the result-ready phase of the idle state: the item is
    // complete and waits for room in the output register
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_done) begin
                    if (i_sts.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_done       = 1'b0;
                    end
                end else if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_cmd)
                        CMD_FIND:     n_state = S_MOD;
                        CMD_SET_SLOT: n_state = S_EXEC;
                        CMD_SET_MAP:  n_state = S_EXEC;
                        CMD_CLR_MAP:  n_state = S_EXEC;
                        CMD_READ_MAP: n_state = S_RDMAP;
                        default:      n_done  = 1'b1;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.chk_v && i_sts.hit) begin
                    o_cmd.probe_hit = 1'b1;
                    if (i_sts.unused && i_sts.own_ok) begin
                        n_state = S_MAPRD;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end else if (i_sts.chk_v && i_sts.last) begin
                    o_cmd.probe_full = 1'b1;
                    n_state          = S_IDLE;
                    n_done           = 1'b1;
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            S_MAPRD: begin
                o_cmd.map_rd_own = 1'b1;
                n_state          = S_MAPCHK;
            end
            S_MAPCHK: begin
                o_cmd.map_chk = 1'b1;
                n_state       = S_IDLE;
                n_done        = 1'b1;
            end
            S_RDMAP: begin
                o_cmd.map_rd_bid = 1'b1;
                n_state          = S_IDLE;
                n_done           = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
                n_done     = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_done  = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || r_done;

    // an item is only taken in idle with no result pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall || r_state == S_IDLE))
    else $error("accepted item did not leave the idle phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !r_done)
    else $error("result phase not left after finish");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
    else $error("input open during clearing pass");

endmodule

// ===== hw/rtl/csp_dp.sv =====
module csp_dp
    import csp_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int BLOCK_IDS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd_bus,
    output t_dp_sts                  o_sts,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [BID_W-1:0]         i_block_id,
    input  logic [SIDX_W-1:0]        i_slot_index,
    input  logic [SST_W-1:0]         i_slot_status,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [SIDX_W-1:0]        o_slot_found,
    output logic signed [POS_W-1:0]  o_position_out,
    output logic                     o_write_back,
    output logic [BID_W-1:0]         o_write_back_id,
    output logic                     o_full_error
);

    localparam int SW    = $clog2(SLOTS);
    localparam int BW    = $clog2(BLOCK_IDS);
    localparam int CLR_N = (SLOTS > BLOCK_IDS) ? SLOTS : BLOCK_IDS;
    localparam int CW    = $clog2(CLR_N);
    localparam int RW    = BID_W + 1;
    localparam int MW    = BID_W + RW;
    localparam int RSH   = BID_W + SW;
    localparam int IDW   = 17;
    localparam int CMPW  = (SW > POS_W - 1) ? SW : POS_W - 1;

    // rounded-up reciprocal of SLOTS, exact quotient for any BID_W-bit id
    localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(SLOTS) - 1)
                               / longint'(SLOTS);

    localparam logic [CW:0]     SLOTS_C = (CW+1)'(SLOTS);
    localparam logic [CW:0]     BIDS_C  = (CW+1)'(BLOCK_IDS);
    localparam logic [SW-1:0]   SLOT_MAX = SW'(SLOTS - 1);
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);

    logic [SST_W-1:0] mem_state [SLOTS];
    logic [BID_W-1:0] mem_owner [SLOTS];
    logic [POS_W-1:0] mem_map   [BLOCK_IDS];

    // captured item
    logic [CMD_W-1:0]  r_cmd;
    logic [BID_W-1:0]  r_bid;
    logic [SIDX_W-1:0] r_sidx;
    logic [SST_W-1:0]  r_sst;
    logic [POS_W-1:0]  r_pos;

    logic [CW-1:0]     r_clr_cnt;
    logic [BID_W-1:0]  r_quo;
    logic              r_mod_ph;
    logic [SW-1:0]     r_paddr;
    logic [SW-1:0]     r_chk;
    logic              r_chk_v;
    logic [SW-1:0]     r_cnt;
    logic [SST_W-1:0]  r_st_q;
    logic [BID_W-1:0]  r_own_q;
    logic [POS_W-1:0]  r_map_q;

    logic [SW-1:0]     r_found;
    logic              r_wb;
    logic [BID_W-1:0]  r_wbid;
    logic              r_full;

    logic              r_o_valid;
    logic [SIDX_W-1:0] r_o_found;
    logic [POS_W-1:0]  r_o_pos;
    logic              r_o_wb;
    logic [BID_W-1:0]  r_o_wbid;
    logic              r_o_full;

    logic [MW-1:0]     quo_prod;
    logic [BID_W-1:0]  quo_nxt;
    logic [MW-1:0]     qs_prod;
    logic [BID_W-1:0]  rem_nxt;
    logic [SW-1:0]     paddr_nxt;
    logic              bid_ok;
    logic              sidx_ok;
    logic              map_match;
    logic [POS_W-1:0]  pos_res;

    logic              slot_we;
    logic [SW-1:0]     slot_wa;
    logic [SST_W-1:0]  slot_wd;
    logic              owner_we;
    logic              map_we;
    logic [BW-1:0]     map_wa;
    logic [POS_W-1:0]  map_wd;
    logic              map_re;
    logic [BW-1:0]     map_ra;

    // block id mod SLOTS by reciprocal multiplication: quotient while r_mod_ph
    // is low, remainder while it is high
    assign quo_prod = {{RW{1'b0}}, r_bid} * {{BID_W{1'b0}}, RECIP};
    assign quo_nxt  = BID_W'(quo_prod >> RSH);
    assign qs_prod  = {{(MW-BID_W){1'b0}}, r_quo} * MW'(SLOTS);
    assign rem_nxt  = r_bid - qs_prod[BID_W-1:0];

    assign paddr_nxt = (r_paddr == SLOT_MAX) ? '0 : r_paddr + 1'b1;
    assign bid_ok    = {{(IDW-BID_W){1'b0}}, r_bid} < IDW'(BLOCK_IDS);
    assign sidx_ok   = {{(IDW-SIDX_W){1'b0}}, r_sidx} < IDW'(SLOTS);
    // only a non-negative stored value equal to the evicted slot is cleared
    assign map_match = !r_map_q[POS_W-1]
                    && (CMPW'(r_map_q[POS_W-2:0]) == CMPW'(r_chk));
    assign pos_res   = (r_cmd != CMD_READ_MAP) ? '0 : (bid_ok ? r_map_q : NONE_POS);

    always_comb begin
        slot_we  = 1'b0;
        slot_wa  = SW'(r_sidx);
        slot_wd  = r_sst;
        owner_we = 1'b0;
        if (i_cmd_bus.clr_en) begin
            slot_we = {1'b0, r_clr_cnt} < SLOTS_C;
            slot_wa = SW'(r_clr_cnt);
            slot_wd = ST_EMPTY;
        end else if (i_cmd_bus.exec && r_cmd == CMD_SET_SLOT && sidx_ok) begin
            slot_we  = 1'b1;
            owner_we = 1'b1;
        end
    end

    always_comb begin
        map_we = 1'b0;
        map_wa = BW'(r_bid);
        map_wd = NONE_POS;
        if (i_cmd_bus.clr_en) begin
            map_we = {1'b0, r_clr_cnt} < BIDS_C;
            map_wa = BW'(r_clr_cnt);
        end else if (i_cmd_bus.exec && bid_ok && r_cmd == CMD_SET_MAP) begin
            map_we = 1'b1;
            map_wd = r_pos;
        end else if (i_cmd_bus.exec && bid_ok && r_cmd == CMD_CLR_MAP) begin
            map_we = 1'b1;
        end else if (i_cmd_bus.map_chk && map_match) begin
            map_we = 1'b1;
            map_wa = BW'(r_wbid);
        end
    end

    assign map_re = i_cmd_bus.map_rd_own || i_cmd_bus.map_rd_bid;
    assign map_ra = i_cmd_bus.map_rd_own ? BW'(r_wbid) : BW'(r_bid);

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            mem_state[slot_wa] <= slot_wd;
        end
        if (owner_we) begin
            mem_owner[slot_wa] <= r_bid;
        end
        if (i_cmd_bus.probe_step) begin
            r_st_q  <= mem_state[r_paddr];
            r_own_q <= mem_owner[r_paddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= mem_map[map_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd_bus.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load) begin
            r_cmd    <= i_cmd;
            r_bid    <= i_block_id;
            r_sidx   <= i_slot_index;
            r_sst    <= i_slot_status;
            r_pos    <= i_position;
            r_mod_ph <= 1'b0;
            r_found  <= '0;
            r_wb     <= 1'b0;
            r_wbid   <= '0;
            r_full   <= 1'b0;
        end
        if (i_cmd_bus.mod_step) begin
            r_mod_ph <= 1'b1;
            if (!r_mod_ph) begin
                r_quo <= quo_nxt;
            end else begin
                r_paddr <= SW'(rem_nxt);
                r_chk_v <= 1'b0;
                r_cnt   <= '0;
            end
        end
        if (i_cmd_bus.probe_step) begin
            r_paddr <= paddr_nxt;
            r_chk   <= r_paddr;
            r_chk_v <= 1'b1;
            if (r_chk_v) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd_bus.probe_hit) begin
            r_found <= r_chk;
            if (r_st_q == ST_UNUSED) begin
                r_wb   <= 1'b1;
                r_wbid <= r_own_q;
            end
        end
        if (i_cmd_bus.probe_full) begin
            r_full <= 1'b1;
        end
    end

    // output register: the next item may be taken while this one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd_bus.finish) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.finish) begin
            r_o_found <= SIDX_W'(r_found);
            r_o_pos   <= pos_res;
            r_o_wb    <= r_wb;
            r_o_wbid  <= r_wbid;
            r_o_full  <= r_full;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == CW'(CLR_N - 1));
    assign o_sts.mod_last = r_mod_ph;
    assign o_sts.chk_v    = r_chk_v;
    assign o_sts.hit      = (r_st_q == ST_EMPTY) || (r_st_q == ST_UNUSED);
    assign o_sts.unused   = (r_st_q == ST_UNUSED);
    assign o_sts.own_ok   = {{(IDW-BID_W){1'b0}}, r_own_q} < IDW'(BLOCK_IDS);
    assign o_sts.last     = (r_cnt == SLOT_MAX);
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid         = r_o_valid;
    assign o_slot_found    = r_o_found;
    assign o_position_out  = r_o_pos;
    assign o_write_back    = r_o_wb;
    assign o_write_back_id = r_o_wbid;
    assign o_full_error    = r_o_full;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.finish |-> (!r_o_valid || !i_stall))
    else $error("result overwritten while still stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_bus.mod_step && r_mod_ph)
            |-> ({{(MW-BID_W){1'b0}}, rem_nxt} < MW'(SLOTS)))
    else $error("probe start not reduced below slot count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_full_error && o_write_back))
    else $error("write-back flagged on a full cache");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.probe_hit |=> (r_wb == ($past(r_st_q) == ST_UNUSED)))
    else $error("write-back flag does not follow probed status");

endmodule
